// File: rtl/bc2_pkg.sv
// Shared types, constants and palette helpers for the BC2 block decoder.
// No dependencies; every other file in rtl/ imports this package.
package bc2_pkg;

   localparam int ALPHA_W = 64;
   localparam int ENDP_W  = 16;
   localparam int INDEX_W = 32;
   localparam int POS_W   = 4;
   localparam int CHAN_W  = 8;
   localparam int NUM_W   = 8;   // 3 * 63 = 189 at most
   localparam int SCALED_W = 14; // 189 * 85 = 16065 at most

   localparam logic [POS_W-1:0] LAST_TEXEL = 4'd15;

   // Palette index codes
   localparam logic [1:0] SEL_EP_A   = 2'd0;
   localparam logic [1:0] SEL_EP_B   = 2'd1;
   localparam logic [1:0] SEL_BLEND1 = 2'd2;

   // x / 31 and x / 63 by reciprocal, 16 fractional bits, rounded down
   localparam logic [11:0] RECIP_31 = 12'd2114;
   localparam logic [11:0] RECIP_63 = 12'd1040;
   localparam int          RECIP_SH = 16;
   localparam logic [5:0]  DIV_5BIT = 6'd31;
   localparam logic [5:0]  DIV_6BIT = 6'd63;
   localparam logic [6:0]  SCALE_K  = 7'd85;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha_bits;
      logic [ENDP_W-1:0]  endpoint_a;
      logic [ENDP_W-1:0]  endpoint_b;
      logic [INDEX_W-1:0] index_bits;
   } block_type;

   typedef struct packed {
      logic [POS_W-1:0] texel_position;
      logic             last;
      logic [3:0]       alpha4;
   } side_type;

   typedef struct packed {
      side_type         side;
      logic [NUM_W-1:0] num_red;
      logic [NUM_W-1:0] num_green;
      logic [NUM_W-1:0] num_blue;
   } texel_type;

   // Palette numerator over 3*max: endpoints scaled by three, blends 2:1 and 1:2
   function automatic logic [NUM_W-1:0] blend_num(input logic [5:0] c0,
                                                  input logic [5:0] c1,
                                                  input logic [1:0] sel);
      logic [NUM_W-1:0] a;
      logic [NUM_W-1:0] b;
      logic [NUM_W-1:0] n;
      a = NUM_W'(c0);
      b = NUM_W'(c1);
      case (sel)
         SEL_EP_A:   n = (a << 1) + a;
         SEL_EP_B:   n = (b << 1) + b;
         SEL_BLEND1: n = (a << 1) + b;
         default:    n = a + (b << 1);
      endcase
      return n;
   endfunction

endpackage

// File: rtl/bc2_req_if.sv
// Block channel carrying one compressed BC2 block per beat.
// Depends on bc2_pkg for field widths.
interface bc2_req_if import bc2_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ALPHA_W-1:0] alpha_bits;
   logic [ENDP_W-1:0]  endpoint_a;
   logic [ENDP_W-1:0]  endpoint_b;
   logic [INDEX_W-1:0] index_bits;

   modport source (output valid, alpha_bits, endpoint_a, endpoint_b, index_bits,
                   input ready);
   modport sink   (input valid, alpha_bits, endpoint_a, endpoint_b, index_bits,
                   output ready);
endinterface

// File: rtl/bc2_rsp_if.sv
// Texel channel carrying one decoded RGBA texel per beat.
// Depends on bc2_pkg for field widths.
interface bc2_rsp_if import bc2_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  texel_position;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic [CHAN_W-1:0] alpha;
   logic              last;

   modport source (output valid, texel_position, red, green, blue, alpha, last,
                   input ready);
   modport sink   (input valid, texel_position, red, green, blue, alpha, last,
                   output ready);
endinterface

// File: rtl/bc2_texel_sel.sv
// Block buffer and texel sequencer: holds one block, walks its 16 texels and
// registers each texel's palette numerators and alpha nibble. Uses bc2_pkg, bc2_req_if.
module bc2_texel_sel import bc2_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   bc2_req_if.sink     req_bus,
   output logic        s1_valid,
   output texel_type   s1_data
);

   logic             blk_valid_ff, blk_valid_in;
   block_type        blk_ff;
   logic [POS_W-1:0] cnt_ff, cnt_in;
   logic             s1_valid_ff, s1_valid_in;
   texel_type        s1_ff, s1_in;
   logic             take;
   logic             final_out;
   logic [1:0]       sel;

   assign final_out = blk_valid_ff && advance && (cnt_ff == LAST_TEXEL);
   assign req_bus.ready = !blk_valid_ff || final_out;
   assign take = req_bus.valid && req_bus.ready;

   always_comb begin
      blk_valid_in = blk_valid_ff;
      cnt_in       = cnt_ff;
      if (take) begin
         blk_valid_in = 1'b1;
         cnt_in       = '0;
      end else if (final_out) begin
         blk_valid_in = 1'b0;
      end else if (blk_valid_ff && advance) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // Index offset is texel*2, alpha offset texel*4 in row-major order
   always_comb begin
      sel = blk_ff.index_bits[{cnt_ff, 1'b0} +: 2];
      s1_in.side.texel_position = cnt_ff;
      s1_in.side.last           = (cnt_ff == LAST_TEXEL);
      s1_in.side.alpha4         = blk_ff.alpha_bits[{cnt_ff, 2'b00} +: 4];
      s1_in.num_red   = blend_num({1'b0, blk_ff.endpoint_a[15:11]},
                                  {1'b0, blk_ff.endpoint_b[15:11]}, sel);
      s1_in.num_green = blend_num(blk_ff.endpoint_a[10:5], blk_ff.endpoint_b[10:5], sel);
      s1_in.num_blue  = blend_num({1'b0, blk_ff.endpoint_a[4:0]},
                                  {1'b0, blk_ff.endpoint_b[4:0]}, sel);
      s1_valid_in = advance ? blk_valid_ff : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         blk_valid_ff <= blk_valid_in;
         cnt_ff       <= cnt_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         blk_ff <= block_type'{req_bus.alpha_bits, req_bus.endpoint_a,
                               req_bus.endpoint_b, req_bus.index_bits};
      end
      if (advance) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_data  = s1_ff;

   a_take_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (take && blk_valid_ff) |-> (advance && cnt_ff == LAST_TEXEL))
      else $error("new block taken before the held block was fully issued");

   a_cnt_zero_after_take: assert property (@(posedge clock) disable iff (reset)
      take |=> (blk_valid_ff && cnt_ff == '0))
      else $error("texel counter not restarted on a new block");

   a_stall_holds_count: assert property (@(posedge clock) disable iff (reset)
      (!advance && !take) |=> $stable(cnt_ff))
      else $error("texel counter moved during a stall");

endmodule

// File: rtl/bc2_chan_scale.sv
// Three-stage channel scaler: floor(num * 255 / (3 * max)) for 5- or 6-bit
// channels, via x = num*85 then reciprocal divide by 31 or 63. Uses bc2_pkg.
module bc2_chan_scale import bc2_pkg::*; (
   input  logic              clock,
   input  logic              advance,
   input  logic              green_mode,
   input  logic [NUM_W-1:0]  num,
   output logic [CHAN_W-1:0] value
);

   logic [SCALED_W-1:0] x2_ff, x2_in;
   logic                m2_ff;
   logic [SCALED_W-1:0] x3_ff;
   logic [CHAN_W-1:0]   q3_ff, q3_in;
   logic                m3_ff;
   logic [CHAN_W-1:0]   v4_ff, v4_in;
   logic [25:0]         prod;
   logic [SCALED_W-1:0] back;
   logic [SCALED_W-1:0] rem;
   logic [5:0]          divisor;

   assign x2_in = SCALED_W'(num) * SCALED_W'(SCALE_K);

   // Estimate is at most one short of the true quotient
   assign prod  = 26'(x2_ff) * 26'(m2_ff ? RECIP_63 : RECIP_31);
   assign q3_in = prod[RECIP_SH +: CHAN_W];

   assign divisor = m3_ff ? DIV_6BIT : DIV_5BIT;
   assign back    = SCALED_W'(q3_ff) * SCALED_W'(divisor);
   assign rem     = x3_ff - back;
   assign v4_in   = (rem >= SCALED_W'(divisor)) ? q3_ff + 1'b1 : q3_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         x2_ff <= x2_in;
         m2_ff <= green_mode;
         x3_ff <= x2_ff;
         q3_ff <= q3_in;
         m3_ff <= m2_ff;
         v4_ff <= v4_in;
      end
   end

   assign value = v4_ff;

endmodule

// File: rtl/bc2_block_decoder.sv
// Top level of the BC2 (DXT3) block decoder: block sequencer, three channel
// scalers and the side-band pipeline. Uses bc2_pkg, bc2_req_if, bc2_rsp_if.
//
//   channel   dir   beat                                      handshake
//   req_bus   in    one 16-byte block (alpha, endpoints, idx)  valid/ready
//   rsp_bus   out   one texel: position, R, G, B, A, last       valid/ready
//
// One block beat yields 16 texel beats, one per cycle while rsp_bus does not stall;
// the single-texel issue of the block buffer sets that rate.
// From a block beat to its first texel the data is registered in the buffer,
// select, scale, reciprocal and correction stages in that order.
// Synchronous active-high reset clears valid bits and the texel counter only.
// A stall on rsp_bus freezes every stage, though an empty block buffer still takes a
// block; the next block is taken in the cycle its predecessor's final texel leaves it.
module bc2_block_decoder import bc2_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   bc2_req_if.sink  req_bus,
   bc2_rsp_if.source rsp_bus
);

   logic      advance;
   logic      s1_valid;
   texel_type s1_data;

   logic      v2_ff, v3_ff, v4_ff;
   side_type  sb2_ff, sb3_ff, sb4_ff;

   logic [CHAN_W-1:0] red_val, green_val, blue_val;

   // Advance the whole pipe unless the output holds a beat nobody takes
   assign advance = !v4_ff || rsp_bus.ready;

   bc2_texel_sel u_sel (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .req_bus  (req_bus),
      .s1_valid (s1_valid),
      .s1_data  (s1_data)
   );

   bc2_chan_scale u_red (
      .clock      (clock),
      .advance    (advance),
      .green_mode (1'b0),
      .num        (s1_data.num_red),
      .value      (red_val)
   );

   bc2_chan_scale u_green (
      .clock      (clock),
      .advance    (advance),
      .green_mode (1'b1),
      .num        (s1_data.num_green),
      .value      (green_val)
   );

   bc2_chan_scale u_blue (
      .clock      (clock),
      .advance    (advance),
      .green_mode (1'b0),
      .num        (s1_data.num_blue),
      .value      (blue_val)
   );

   // Valid bits and side-band fields travel in step with the scalers
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= s1_valid;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sb2_ff <= s1_data.side;
         sb3_ff <= sb2_ff;
         sb4_ff <= sb3_ff;
      end
   end

   assign rsp_bus.valid          = v4_ff;
   assign rsp_bus.texel_position = sb4_ff.texel_position;
   assign rsp_bus.red            = red_val;
   assign rsp_bus.green          = green_val;
   assign rsp_bus.blue           = blue_val;
   assign rsp_bus.alpha          = {sb4_ff.alpha4, sb4_ff.alpha4}; // a4 * 17
   assign rsp_bus.last           = sb4_ff.last;

   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.last == (rsp_bus.texel_position == LAST_TEXEL)))
      else $error("last mark not on the final texel of a block");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (advance && v3_ff) |=> (v4_ff && sb4_ff == $past(sb3_ff)))
      else $error("texel lost between side-band stages");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (!advance && v2_ff) |=> (v2_ff && $stable(sb2_ff)))
      else $error("pipeline stage changed during a stall");

endmodule
